// File: hdl/efr_pkg.sv
package efr_pkg;

    // Framing bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7F;
    localparam logic [7:0] ESC_BYTE  = 8'h27;
    localparam logic [7:0] ESC_LIT   = 8'h28;

    // Width of the delivered payload counter
    localparam int COUNT_W = 16;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TYPE,
        PH_PAYLOAD,
        PH_END
    } phase_t;

    // Result kind
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

endpackage

// File: hdl/escaped_frame_receiver_core.sv
// An accepted word loads its result, if any, into the result register; it shows in the next cycle.
// Throughput: one received word per cycle while rx_stall is low; the parse state updates on each accepted word.
// A held result does not block input while it is being taken in the same cycle.
// Reset (rst_n, async, active low): parser hunts for the flag, counters, type and
// escape flag cleared, no result pending.
module escaped_frame_receiver_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    output logic                          rx_stall,
    input  logic [7:0]                    rx_byte,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [1:0]                    out_kind,
    output logic [7:0]                    out_byte,
    output logic [7:0]                    frame_type,
    output logic [efr_pkg::COUNT_W-1:0]   payload_count,
    output logic                          last
);
    import efr_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [LENGTH_BITS-1:0]   left_reg, left_next;
    logic                     esc_reg, esc_next;
    logic [7:0]               type_reg, type_next;
    logic [COUNT_W-1:0]       count_reg, count_next;

    logic                     res_valid_reg, res_valid_next;
    kind_t                    kind_reg, kind_next;
    logic [7:0]               byte_reg, byte_next;
    logic [7:0]               ftype_reg, ftype_next;
    logic [COUNT_W-1:0]       pcount_reg, pcount_next;

    logic                     rx_accept;
    logic                     emit;
    kind_t                    emit_kind;
    logic [7:0]               emit_byte;
    logic [COUNT_W-1:0]       emit_count;
    logic [15:0]              hi_word;
    logic                     is_flag;
    logic                     end_of_len;

    // Take a word whenever the result register is free or draining
    assign rx_stall  = res_valid_reg & res_stall;
    assign rx_accept = rx_valid & ~rx_stall;

    assign hi_word    = {rx_byte, 8'h00};
    assign is_flag    = (rx_byte == FLAG_BYTE);
    assign end_of_len = (left_reg == LENGTH_BITS'(1));

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:    phase_next = is_flag ? PH_LEN_HI : PH_HUNT;
            PH_LEN_HI:  phase_next = PH_LEN_LO;
            PH_LEN_LO:  phase_next = PH_TYPE;
            PH_TYPE:    phase_next = (left_reg == '0) ? PH_END : PH_PAYLOAD;
            PH_PAYLOAD:
            begin
                if (is_flag)
                    phase_next = PH_LEN_HI;
                else if (end_of_len)
                    phase_next = PH_END;
            end
            PH_END:     phase_next = PH_HUNT;
            default:    phase_next = PH_HUNT;
        endcase
    end

    // Datapath and result generation
    always_comb
    begin
        left_next  = left_reg;
        esc_next   = esc_reg;
        type_next  = type_reg;
        count_next = count_reg;
        emit       = 1'b0;
        emit_kind  = KIND_DATA;
        emit_byte  = 8'h00;
        emit_count = count_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (is_flag)
                begin
                    left_next  = '0;
                    esc_next   = 1'b0;
                    type_next  = 8'h00;
                    count_next = '0;
                end
            end
            PH_LEN_HI:  left_next = hi_word[LENGTH_BITS-1:0];
            PH_LEN_LO:  left_next = left_reg | LENGTH_BITS'(rx_byte);
            PH_TYPE:    type_next = rx_byte;
            PH_PAYLOAD:
            begin
                if (is_flag)
                begin
                    // flag inside payload: abort, flag opens the next frame
                    emit       = 1'b1;
                    emit_kind  = KIND_BAD;
                    left_next  = '0;
                    esc_next   = 1'b0;
                    type_next  = 8'h00;
                    count_next = '0;
                end
                else
                begin
                    left_next = left_reg - LENGTH_BITS'(1);
                    if (esc_reg)
                    begin
                        esc_next   = 1'b0;
                        emit       = 1'b1;
                        emit_byte  = (rx_byte == ESC_LIT) ? ESC_BYTE : FLAG_BYTE;
                        count_next = count_reg + COUNT_W'(1);
                        emit_count = count_next;
                    end
                    else if (rx_byte == ESC_BYTE)
                        esc_next = 1'b1;
                    else
                    begin
                        emit       = 1'b1;
                        emit_byte  = rx_byte;
                        count_next = count_reg + COUNT_W'(1);
                        emit_count = count_next;
                    end
                end
            end
            PH_END:
            begin
                emit      = 1'b1;
                emit_kind = (is_flag && !esc_reg) ? KIND_GOOD : KIND_BAD;
                esc_next  = 1'b0;
                left_next = '0;
            end
            default: ;
        endcase
    end

    // Result register load and drain
    always_comb
    begin
        res_valid_next = res_valid_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        ftype_next     = ftype_reg;
        pcount_next    = pcount_reg;
        if (rx_accept)
        begin
            res_valid_next = emit;
            if (emit)
            begin
                kind_next   = emit_kind;
                byte_next   = emit_byte;
                ftype_next  = type_reg;
                pcount_next = emit_count;
            end
        end
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            left_reg      <= '0;
            esc_reg       <= 1'b0;
            type_reg      <= 8'h00;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (rx_accept)
            begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                esc_reg   <= esc_next;
                type_reg  <= type_next;
                count_reg <= count_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        ftype_reg  <= ftype_next;
        pcount_reg <= pcount_next;
    end

    assign res_valid     = res_valid_reg;
    assign out_kind      = kind_reg;
    assign out_byte      = byte_reg;
    assign frame_type    = ftype_reg;
    assign payload_count = pcount_reg;
    assign last          = (kind_reg != KIND_DATA);

    // Checks
    a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (out_kind != KIND_DATA) |-> out_byte == 8'h00)
        else $error("status word carries nonzero byte");

    a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept && (phase_reg == PH_HUNT) |=> !res_valid)
        else $error("result produced while hunting");

    a_escape_end_bad: assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept && (phase_reg == PH_END) && esc_reg |=>
            res_valid && (out_kind == KIND_BAD))
        else $error("frame ending on escape not reported bad");

    a_payload_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept && (phase_reg == PH_PAYLOAD) && !is_flag |=>
            left_reg == $past(left_reg) - LENGTH_BITS'(1))
        else $error("payload length did not count down");

    a_data_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept && emit && (emit_kind == KIND_DATA) |=>
            payload_count == $past(count_reg) + COUNT_W'(1))
        else $error("data word count mismatch");

endmodule
